@@ hdl/texture_region_decode_hash_assert.svh @@
// Assertion macros used by the checker file of the texture region hash block.
// No dependencies; pulled in by `include.
`ifndef TEXTURE_REGION_DECODE_HASH_ASSERT_SVH
`define TEXTURE_REGION_DECODE_HASH_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define TRDH_ASSERT_NOW(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("trdh assertion failed");

// Next-cycle implication, disabled in reset.
`define TRDH_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("trdh assertion failed");

`endif

@@ hdl/trdh_pkg.sv @@
// Types and constants for the texture region decode and hash block.
// No dependencies.
package trdh_pkg;

  localparam int MEM_WIDTH_DEF  = 1024;
  localparam int MEM_HEIGHT_DEF = 512;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  localparam logic KIND_WRITE   = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  localparam logic [1:0] MODE_PAL4 = 2'd0;
  localparam logic [1:0] MODE_PAL8 = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TEX,
    ST_PAL,
    ST_HASH,
    ST_DONE
  } state_t;

endpackage

@@ hdl/texture_region_decode_hash.sv @@
// Texture region decode and FNV-1a hash, top level.
// Depends on trdh_pkg.
//
// A write transaction (kind 0) stores one 16-bit word without leaving the idle
// state; it gives no result, and writes past the end of memory are dropped. A
// request (kind 1) walks the u/v rectangle row by row through a small
// sequencer: per texel one read of the texture word, one more read of the
// palette word in the 4-bit and 8-bit palette modes, then the one shared 32x32
// multiplier folds bytes b, g, r, a into the hash in turn. Texels are handled
// one after another; the single memory read port and the one multiplier set
// the pace. An inverted rectangle returns digest 0 with ok 0. Input is
// stalled while a request runs. Memory contents are undefined until written;
// there is no clear pass.
module texture_region_decode_hash
  import trdh_pkg::*;
#(
  parameter int MEM_WIDTH  = MEM_WIDTH_DEF,
  parameter int MEM_HEIGHT = MEM_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [18:0] mem_addr,
  input  logic [15:0] mem_data,
  input  logic [15:0] page_word,
  input  logic [15:0] palette_word,
  input  logic [7:0]  u_low,
  input  logic [7:0]  v_low,
  input  logic [7:0]  u_high,
  input  logic [7:0]  v_high,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest,
  output logic        ok
);

  localparam int COL_W     = $clog2(MEM_WIDTH);
  localparam int ROW_W     = $clog2(MEM_HEIGHT);
  localparam int ADDR_W    = COL_W + ROW_W;
  localparam int MEM_WORDS = MEM_WIDTH * MEM_HEIGHT;

  state_t state, state_next;

  logic [1:0]  mode, mode_next;
  logic [3:0]  page_x, page_x_next;
  logic        page_y, page_y_next;
  logic [5:0]  pal_x, pal_x_next;
  logic [9:0]  pal_y, pal_y_next;
  logic [7:0]  ulo, ulo_next;
  logic [7:0]  uhi, uhi_next;
  logic [7:0]  vhi, vhi_next;
  logic [7:0]  texel_row, texel_row_next;
  logic [7:0]  texel_column, texel_column_next;
  logic [31:0] acc, acc_next;
  logic        ok_reg, ok_reg_next;
  logic [1:0]  byte_cnt, byte_cnt_next;
  logic        out_valid_next;
  logic [31:0] digest_next;
  logic        ok_next;

  logic [15:0]       mem [MEM_WORDS];
  logic [15:0]       rd_data;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] rd_addr;

  logic        in_acc, out_acc;
  logic [15:0] tex_row16, tex_col16, tex_off16;
  logic [15:0] pal_row16, pal_col16;
  logic [7:0]  pal_idx;
  logic [7:0]  hbyte;
  logic [31:0] hash_mix;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign in_stall = (state != ST_IDLE);

  // Texture word address; the column offset depends on texels per word.
  always_comb begin
    case (mode)
      MODE_PAL4: tex_off16 = {10'd0, texel_column[7:2]};
      MODE_PAL8: tex_off16 = {9'd0, texel_column[7:1]};
      default:   tex_off16 = {8'd0, texel_column};
    endcase
  end
  assign tex_row16 = {7'd0, page_y, texel_row};
  assign tex_col16 = {6'd0, page_x, 6'd0} + tex_off16;

  // Palette index taken from the word read in the previous cycle.
  always_comb begin
    if (mode == MODE_PAL4) begin
      case (texel_column[1:0])
        2'd0:    pal_idx = {4'd0, rd_data[3:0]};
        2'd1:    pal_idx = {4'd0, rd_data[7:4]};
        2'd2:    pal_idx = {4'd0, rd_data[11:8]};
        default: pal_idx = {4'd0, rd_data[15:12]};
      endcase
    end else begin
      pal_idx = texel_column[0] ? rd_data[15:8] : rd_data[7:0];
    end
  end
  assign pal_row16 = {6'd0, pal_y};
  assign pal_col16 = {6'd0, pal_x, 4'd0} + {8'd0, pal_idx};

  // Byte of the colour word held in rd_data, in b, g, r, a order.
  always_comb begin
    case (byte_cnt)
      2'd0:    hbyte = {rd_data[14:10], 3'd0};
      2'd1:    hbyte = {rd_data[9:5], 3'd0};
      2'd2:    hbyte = {rd_data[4:0], 3'd0};
      default: hbyte = (rd_data == 16'd0) ? 8'd0 : 8'hFF;
    endcase
  end
  assign hash_mix = (acc ^ {24'd0, hbyte}) * FNV_PRIME;

  always_comb begin
    state_next        = state;
    mode_next         = mode;
    page_x_next       = page_x;
    page_y_next       = page_y;
    pal_x_next        = pal_x;
    pal_y_next        = pal_y;
    ulo_next          = ulo;
    uhi_next          = uhi;
    vhi_next          = vhi;
    texel_row_next    = texel_row;
    texel_column_next = texel_column;
    acc_next          = acc;
    ok_reg_next       = ok_reg;
    byte_cnt_next     = byte_cnt;
    out_valid_next    = out_acc ? 1'b0 : out_valid;
    digest_next       = digest;
    ok_next           = ok;
    mem_we            = 1'b0;
    mem_re            = 1'b0;
    rd_addr           = {tex_row16[ROW_W-1:0], tex_col16[COL_W-1:0]};

    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (kind == KIND_WRITE) begin
            mem_we = (32'(mem_addr) < 32'(MEM_WORDS));
          end else begin
            mode_next         = page_word[8:7];
            page_x_next       = page_word[3:0];
            page_y_next       = page_word[4];
            pal_x_next        = palette_word[5:0];
            pal_y_next        = palette_word[15:6];
            ulo_next          = u_low;
            uhi_next          = u_high;
            vhi_next          = v_high;
            texel_row_next    = v_low;
            texel_column_next = u_low;
            byte_cnt_next     = 2'd0;
            if (u_high < u_low || v_high < v_low) begin
              acc_next    = '0;
              ok_reg_next = 1'b0;
              state_next  = ST_DONE;
            end else begin
              acc_next    = FNV_BASIS;
              ok_reg_next = 1'b1;
              state_next  = ST_TEX;
            end
          end
        end
      end
      ST_TEX: begin
        mem_re     = 1'b1;
        state_next = mode[1] ? ST_HASH : ST_PAL;
      end
      ST_PAL: begin
        mem_re     = 1'b1;
        rd_addr    = {pal_row16[ROW_W-1:0], pal_col16[COL_W-1:0]};
        state_next = ST_HASH;
      end
      ST_HASH: begin
        acc_next      = hash_mix;
        byte_cnt_next = byte_cnt + 2'd1;
        if (byte_cnt == 2'd3) begin
          state_next = ST_TEX;
          if (texel_column == uhi) begin
            texel_column_next = ulo;
            if (texel_row == vhi) begin
              state_next = ST_DONE;
            end else begin
              texel_row_next = texel_row + 8'd1;
            end
          end else begin
            texel_column_next = texel_column + 8'd1;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          out_valid_next = 1'b1;
          digest_next    = acc;
          ok_next        = ok_reg;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[ADDR_W'(mem_addr)] <= mem_data;
    end
    if (mem_re) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      byte_cnt  <= 2'd0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      byte_cnt  <= byte_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    mode         <= mode_next;
    page_x       <= page_x_next;
    page_y       <= page_y_next;
    pal_x        <= pal_x_next;
    pal_y        <= pal_y_next;
    ulo          <= ulo_next;
    uhi          <= uhi_next;
    vhi          <= vhi_next;
    texel_row    <= texel_row_next;
    texel_column <= texel_column_next;
    acc          <= acc_next;
    ok_reg       <= ok_reg_next;
    digest       <= digest_next;
    ok           <= ok_next;
  end

endmodule

@@ hdl/trdh_checker.sv @@
// Port-level checks for texture_region_decode_hash, bound to the top level.
// Depends on trdh_pkg and texture_region_decode_hash_assert.svh.
`include "texture_region_decode_hash_assert.svh"

module trdh_checker
  import trdh_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        kind,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] digest,
  input logic        ok
);

  // A stalled result stays up with the same digest.
  `TRDH_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(digest))
  // A rejected rectangle always reports a zero digest.
  `TRDH_ASSERT_NOW(a_bad_zero, clk, rst, out_valid && !ok, digest == 32'd0)
  // A request transaction keeps the input stalled while it runs.
  `TRDH_ASSERT_NEXT(a_req_busy, clk, rst, in_valid && !in_stall && kind == KIND_REQUEST, in_stall)
  // A write transaction does not stall the input in the following cycle.
  `TRDH_ASSERT_NEXT(a_wr_fast, clk, rst, in_valid && !in_stall && kind == KIND_WRITE, !in_stall)

endmodule

bind texture_region_decode_hash trdh_checker u_trdh_checker (.*);
